// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both forms take a label, a clock,
// an active-low reset and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_n_sig, cond, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond)) \
		else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk_sig, rst_n_sig, cond, msg)
`define ASSERT_IMPLIES(label, clk_sig, rst_n_sig, ante, cons, msg)

`endif

`endif

// ----- rtl/stnv_pkg.sv -----
package stnv_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int VALUE_BITS  = 16;

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic signed [VALUE_BITS:0]   wide_t;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Reported as the nearest value when the table holds nothing.
	localparam val_t NO_ENTRY = '1;

	typedef struct packed {
		logic [1:0] op;
		val_t       value;
	} item_t;

	typedef struct packed {
		val_t                  nearest;
		logic [VALUE_BITS-1:0] distance;
		logic                  empty_res;
	} result_t;

	// Broadcast to every cell of the table.
	typedef struct packed {
		logic load;
		logic clear;
		val_t value;
	} cmd_t;

	// What a cell shows to its right-hand neighbor.
	typedef struct packed {
		logic valid;
		logic gt;
		val_t entry;
	} nbr_t;

	// Bracketing entries found for one query.
	typedef struct packed {
		logic has_lo;
		logic has_hi;
		val_t lo;
		val_t hi;
		val_t pt;
	} cand_t;

endpackage

// ----- rtl/stnv_cell.sv -----
module stnv_cell import stnv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  nbr_t left,
	output nbr_t self,
	output logic below
);

	logic valid_q;
	val_t entry_q;
	logic gt;

	// An empty cell counts as greater, so the new value lands at the first free place.
	assign gt    = !valid_q || (entry_q > cmd.value);
	assign below = valid_q && (entry_q < cmd.value);

	assign self.valid = valid_q;
	assign self.gt    = gt;
	assign self.entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= valid_q || left.valid;
		end
	end

	// Cells above the insert point take their neighbor's entry; the first one takes the value.
	always_ff @(posedge clk) begin
		if (cmd.load && gt) begin
			entry_q <= left.gt ? left.entry : cmd.value;
		end
	end

endmodule

// ----- rtl/stnv_select.sv -----
module stnv_select import stnv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  cand_t   cand,
	output logic    adv,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	wide_t   d_lo;
	wide_t   d_hi;
	logic    lo_wins;
	result_t res_d;
	logic    valid_q;
	result_t res_q;

	// Both differences are non-negative: lo lies below the point, hi at or above it.
	assign d_lo = wide_t'(cand.pt) - wide_t'(cand.lo);
	assign d_hi = wide_t'(cand.hi) - wide_t'(cand.pt);
	assign lo_wins = cand.has_lo && (!cand.has_hi || (d_lo < d_hi));

	always_comb begin
		if (!cand.has_lo && !cand.has_hi) begin
			res_d.nearest   = NO_ENTRY;
			res_d.distance  = '0;
			res_d.empty_res = 1'b1;
		end else if (lo_wins) begin
			res_d.nearest   = cand.lo;
			res_d.distance  = d_lo[VALUE_BITS-1:0];
			res_d.empty_res = 1'b0;
		end else begin
			res_d.nearest   = cand.hi;
			res_d.distance  = d_hi[VALUE_BITS-1:0];
			res_d.empty_res = 1'b0;
		end
	end

	assign adv          = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- rtl/sorted_table_nearest_value.sv -----
// Sorted table with nearest-value lookup.
// The item channel (item_valid, item_stall, item) carries an opcode and a signed
// value: clear empties the table, load inserts the value in ascending order after
// any equal entries, query asks for the stored value closest to the point. A load
// into a full table is dropped, and the unused opcode is ignored.
// Only a query produces a transaction on the result channel (result_valid,
// result_stall, result): the nearest value, its absolute distance, and an empty
// flag. An exact match wins, a tie between the lower and higher neighbor goes to
// the higher one, and an empty table gives -1 with the flag set.
// The table is a row of cells, each holding one entry; a load shifts the larger
// entries one cell up. For a query the cells find the bracketing entries, which
// are held in the middle stage, then a subtract-and-compare picks one and
// registers the result. One item is taken per cycle while results flow.
// When result_stall holds a result, one more query can wait in the middle stage,
// and after that item_stall rises until the result is taken.
// Reset empties the table and drops any query in flight.
`include "assert_macros.svh"

module sorted_table_nearest_value import stnv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	cmd_t                   cmd;
	nbr_t                   cell_out [TABLE_DEPTH];
	nbr_t                   cell_in  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] below;
	logic [TABLE_DEPTH-1:0] valid_vec;
	logic [TABLE_DEPTH-1:0] lo_sel;
	logic [TABLE_DEPTH-1:0] hi_sel;
	logic                   accept;
	logic                   full;
	logic                   adv;
	cand_t                  cand_d;
	cand_t                  cand_s1;
	logic                   valid_s1;

	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;
	assign full       = cell_out[TABLE_DEPTH-1].valid;

	assign cmd.load  = accept && (item.op == OP_LOAD) && !full;
	assign cmd.clear = accept && (item.op == OP_CLEAR);
	assign cmd.value = item.value;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign cell_in[gi].valid = 1'b1;
				assign cell_in[gi].gt    = 1'b0;
				assign cell_in[gi].entry = '0;
			end else begin : g_rest
				assign cell_in[gi] = cell_out[gi-1];
			end

			stnv_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.cmd   (cmd),
				.left  (cell_in[gi]),
				.self  (cell_out[gi]),
				.below (below[gi])
			);

			assign valid_vec[gi] = cell_out[gi].valid;

			// The last entry below the point and the first entry at or above it.
			if (gi == TABLE_DEPTH - 1) begin : g_lo_last
				assign lo_sel[gi] = below[gi];
			end else begin : g_lo_mid
				assign lo_sel[gi] = below[gi] && !below[gi+1];
			end
			if (gi == 0) begin : g_hi_first
				assign hi_sel[gi] = valid_vec[gi] && !below[gi];
			end else begin : g_hi_mid
				assign hi_sel[gi] = valid_vec[gi] && !below[gi] && below[gi-1];
			end
		end
	endgenerate

	always_comb begin
		cand_d.has_lo = |lo_sel;
		cand_d.has_hi = |hi_sel;
		cand_d.lo     = '0;
		cand_d.hi     = '0;
		cand_d.pt     = item.value;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			cand_d.lo = cand_d.lo | (cell_out[i].entry & {VALUE_BITS{lo_sel[i]}});
			cand_d.hi = cand_d.hi | (cell_out[i].entry & {VALUE_BITS{hi_sel[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= accept && (item.op == OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.op == OP_QUERY)) begin
			cand_s1 <= cand_d;
		end
	end

	stnv_select u_select (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (valid_s1),
		.cand        (cand_s1),
		.adv         (adv),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	`ASSERT_ALWAYS(a_lo_onehot, clk, arst_n, $onehot0(lo_sel), "several lower neighbors selected")
	`ASSERT_ALWAYS(a_hi_onehot, clk, arst_n, $onehot0(hi_sel), "several upper neighbors selected")

	generate
		for (gi = 1; gi < TABLE_DEPTH; gi++) begin : g_chk
			`ASSERT_IMPLIES(a_prefix, clk, arst_n, valid_vec[gi], valid_vec[gi-1], "gap in table")
			`ASSERT_IMPLIES(a_sorted, clk, arst_n, valid_vec[gi], cell_out[gi-1].entry <= cell_out[gi].entry, "table out of order")
		end
	endgenerate

endmodule

// ----- bench/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stnv_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 650;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PERCENT  = 23;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		item_t it;
		bit    drain_first;
	} pending_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	pending_t pending_q[$];
	result_t  awaited_answers[$];
	val_t     table_mirror[TABLE_DEPTH];
	int       mirror_fill = 0;
	int       item_count = 0;
	int       issued = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	logic     item_fire;
	logic     calm;

	// Neither side idles while this window of transactions goes through.
	assign calm = (issued >= 250) && (issued < 400);

	sorted_table_nearest_value DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic queue_item(input logic [1:0] op, input val_t value, input bit drain = 0);
		pending_t p;
		p.it.op = op;
		p.it.value = value;
		p.drain_first = drain;
		pending_q.push_back(p);
		if (op != OP_UNUSED)
			item_count++;
	endtask

	function automatic val_t pick_value(input int spread);
		case (spread)
			0: return val_t'(int'($urandom_range(0, 16)) - 8);
			1: return val_t'(int'($urandom_range(0, 4000)) - 2000);
			default:
				case ($urandom_range(0, 3))
					0: return $urandom_range(0, 1) ? val_t'(32767) : val_t'(-32768);
					1: return val_t'(32767 - int'($urandom_range(0, 3)));
					2: return val_t'(-32768 + int'($urandom_range(0, 3)));
					default: return val_t'($urandom);
				endcase
		endcase
	endfunction

	task automatic build_stimulus();
		int spread;
		int n;
		queue_item(OP_QUERY, val_t'(0));
		queue_item(OP_UNUSED, val_t'(5));
		queue_item(OP_LOAD, val_t'(-32768));
		queue_item(OP_LOAD, val_t'(32767));
		queue_item(OP_QUERY, val_t'(-32768));
		queue_item(OP_QUERY, val_t'(32767));
		queue_item(OP_QUERY, val_t'(0));
		queue_item(OP_QUERY, val_t'(-1));
		queue_item(OP_CLEAR, val_t'(-1), 1);
		queue_item(OP_QUERY, val_t'(32767));
		queue_item(OP_LOAD, val_t'(10));
		queue_item(OP_LOAD, val_t'(20));
		queue_item(OP_LOAD, val_t'(20));
		queue_item(OP_QUERY, val_t'(15));
		queue_item(OP_QUERY, val_t'(14));
		queue_item(OP_QUERY, val_t'(5));
		queue_item(OP_QUERY, val_t'(100));
		queue_item(OP_QUERY, val_t'(20));

		while (item_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 80) begin
				// Fill a table and ask about it; a narrow spread gives duplicates
				// and ties, more than 16 loads runs into the full table.
				spread = $urandom_range(0, 2);
				if ($urandom_range(0, 3) != 0)
					queue_item(OP_CLEAR, val_t'($urandom), $urandom_range(0, 19) == 0);
				n = $urandom_range(1, 20);
				repeat (n) queue_item(OP_LOAD, pick_value(spread));
				n = $urandom_range(1, 8);
				repeat (n) queue_item(OP_QUERY, pick_value(spread));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) queue_item(2'($urandom_range(0, 3)), pick_value(2));
			end
		end
	endtask

	task automatic mirror_item(input item_t it);
		int pos;
		int k;
		int pt;
		int lo;
		int hi;
		int pick;
		result_t r;
		pt = int'(it.value);
		case (it.op)
			OP_CLEAR: mirror_fill = 0;
			OP_LOAD: begin
				if (mirror_fill < TABLE_DEPTH) begin
					pos = 0;
					while (pos < mirror_fill && table_mirror[pos] <= it.value)
						pos++;
					for (k = mirror_fill; k > pos; k--)
						table_mirror[k] = table_mirror[k - 1];
					table_mirror[pos] = it.value;
					mirror_fill++;
				end
			end
			OP_QUERY: begin
				if (mirror_fill == 0) begin
					r.nearest = NO_ENTRY;
					r.distance = '0;
					r.empty_res = 1'b1;
				end else begin
					pos = 0;
					while (pos < mirror_fill && int'(table_mirror[pos]) < pt)
						pos++;
					if (pos < mirror_fill && int'(table_mirror[pos]) == pt) begin
						pick = pt;
					end else if (pos >= mirror_fill) begin
						pick = int'(table_mirror[mirror_fill - 1]);
					end else if (pos == 0) begin
						pick = int'(table_mirror[0]);
					end else begin
						// A tie goes to the higher neighbor.
						lo = int'(table_mirror[pos - 1]);
						hi = int'(table_mirror[pos]);
						pick = (pt - lo < hi - pt) ? lo : hi;
					end
					r.nearest = val_t'(pick);
					r.distance = VALUE_BITS'((pick > pt) ? pick - pt : pt - pick);
					r.empty_res = 1'b0;
				end
				awaited_answers.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string text);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, text);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (awaited_answers.size() == 0) begin
			flag_mismatch($sformatf("unexpected result nearest=%0d distance=%0d empty=%0b",
				got.nearest, got.distance, got.empty_res));
		end else begin
			want = awaited_answers.pop_front();
			if (got.nearest !== want.nearest || got.distance !== want.distance
					|| got.empty_res !== want.empty_res)
				flag_mismatch($sformatf(
					"expected nearest=%0d distance=%0d empty=%0b, got %0d %0d %0b",
					want.nearest, want.distance, want.empty_res,
					got.nearest, got.distance, got.empty_res));
		end
	endtask

	// Driver: a new transaction is offered only once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n) begin
			result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
			if (!item_valid || item_fire) begin
				if (pending_q.size() == 0 || (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
						|| (pending_q[0].drain_first && awaited_answers.size() != 0)) begin
					item_valid <= 1'b0;
				end else begin
					item <= pending_q[0].it;
					item_valid <= 1'b1;
					pending_q.pop_front();
					issued++;
				end
			end
		end
	end

	// Monitor: results are checked before the same edge's input updates the mirror.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result(result);
			if (item_valid && !item_stall)
				mirror_item(item);
			item_fire <= item_valid && !item_stall;
		end else begin
			item_fire <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL sorted_table_nearest_value");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		item_fire = 1'b0;
		build_stimulus();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || item_valid)
			@(posedge clk);
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_answers.size() == 0)
			$display("PASS sorted_table_nearest_value");
		else
			$display("FAIL sorted_table_nearest_value");
		$finish;
	end

endmodule
